// ===== design/cdre_pkg.sv =====
`timescale 1ns / 1ps
package cdre_pkg;
    localparam int CrcW = 32;
    localparam int LenW = 17;
    localparam int BlkW = 32;
    localparam int BytW = 48;
    localparam int LimW = 10;

    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_END    = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    localparam logic [2:0] ST_OUTSIDE = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_NEW     = 3'd2;
    localparam logic [2:0] ST_DROP    = 3'd3;
    localparam logic [2:0] ST_CTRL    = 3'd4;

    localparam logic [BytW-1:0] MAX48 = {BytW{1'b1}};
    localparam logic [BlkW-1:0] MAX32 = {BlkW{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_EVICT, S_LOOK, S_FILL, S_SUM, S_DIV, S_ACC, S_OUT, S_WIPE
    } state_t;

    // controller commands into datapath
    typedef struct packed {
        logic latch;      // capture input item
        logic clr_tot;    // clear totals and window
        logic shrink;     // move window end halfway toward start
        logic scan_rst;   // restart scan index
        logic scan_inc;   // step scan index
        logic evict;      // evict entry read last cycle if at or above end
        logic look;       // compare at scan index
        logic hit_upd;    // update hit entry
        logic fill;       // write new entry at free slot
        logic clr_step;   // clear entry count
        logic wipe;       // clear valid bit at scan index
        logic unset;      // clear valid bit of entry read last cycle
        logic div_start;  // start divide for scan entry
        logic acc;        // accumulate into totals
        logic pass_end;   // move window, set more flag
        logic [2:0] status;
        logic shrunk;
        logic out_load;   // load output register
    } cmd_t;

    // datapath status into controller
    typedef struct packed {
        logic outside;
        logic over_limit;
        logic scan_last;
        logic idx_last;   // scan index at last entry
        logic match;      // current entry matches crc
        logic any_free;
        logic div_done;
        logic valid_ent;  // scan entry valid and blocks nonzero
        logic [1:0] req;
    } stat_t;
endpackage

// ===== design/cdre_if.sv =====
`timescale 1ns / 1ps
interface cdre_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [cdre_pkg::CrcW-1:0] block_crc;
    logic [cdre_pkg::LenW-1:0] block_len;
    modport source (output valid, req_type, block_crc, block_len, input ready);
    modport sink (input valid, req_type, block_crc, block_len, output ready);
endinterface

// ===== design/cdre_res_if.sv =====
`timescale 1ns / 1ps
interface cdre_res_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                record_status;
    logic                      window_shrunk;
    logic [cdre_pkg::BytW-1:0] referenced_total;
    logic [cdre_pkg::BytW-1:0] allocated_total;
    logic                      more_passes;
    logic [cdre_pkg::CrcW-1:0] next_window_start;
    modport source (output valid, record_status, window_shrunk, referenced_total,
        allocated_total, more_passes, next_window_start, input ready);
    modport sink (input valid, record_status, window_shrunk, referenced_total,
        allocated_total, more_passes, next_window_start, output ready);
endinterface

// ===== design/cdre_cfg_if.sv =====
`timescale 1ns / 1ps
interface cdre_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cdre_pkg::LimW-1:0] entry_limit;
    modport source (output valid, entry_limit, input ready);
    modport sink (input valid, entry_limit, output ready);
endinterface

// ===== design/cdre_div.sv =====
`timescale 1ns / 1ps
module cdre_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cdre_pkg::BytW-1:0] dividend,
    input  logic [cdre_pkg::BlkW-1:0] divisor,
    output logic                      done,
    output logic [cdre_pkg::BytW-1:0] quotient
);
    import cdre_pkg::*;

    logic [BytW-1:0] quo_reg;
    logic [BlkW:0]   rem_reg;
    logic [BlkW-1:0] dsr_reg;
    logic [5:0]      cnt_reg;
    logic            busy_reg;
    logic [BlkW:0]   trial;
    logic [BlkW:0]   shifted;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg[BlkW-1:0], quo_reg[BytW-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(BytW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[BlkW])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[BytW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[BytW-2:0], 1'b0};
            end
        end
    end

    assign done     = !busy_reg && !start;
    assign quotient = quo_reg;
endmodule

// ===== design/cdre_datapath.sv =====
`timescale 1ns / 1ps
module cdre_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cdre_pkg::cmd_t            cmd,
    output cdre_pkg::stat_t           stat,
    input  logic [1:0]                in_req,
    input  logic [cdre_pkg::CrcW-1:0] in_crc,
    input  logic [cdre_pkg::LenW-1:0] in_len,
    input  logic [cdre_pkg::LimW-1:0] entry_limit,
    output logic [2:0]                o_status,
    output logic                      o_shrunk,
    output logic [cdre_pkg::BytW-1:0] o_ref,
    output logic [cdre_pkg::BytW-1:0] o_alloc,
    output logic                      o_more,
    output logic [cdre_pkg::CrcW-1:0] o_start
);
    import cdre_pkg::*;

    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW = $clog2(TABLE_DEPTH + 1);
    localparam int CmpW = (CntW > LimW) ? CntW : LimW;

    // table memories and valid bits
    logic [CrcW-1:0] mem_crc [TABLE_DEPTH];
    logic [BlkW-1:0] mem_blk [TABLE_DEPTH];
    logic [BytW-1:0] mem_byt [TABLE_DEPTH];
    logic            mem_vld [TABLE_DEPTH];

    logic [1:0]      req_reg;
    logic [CrcW-1:0] crc_reg;
    logic [LenW-1:0] len_reg;
    logic [CntW-1:0] count_reg;
    logic [CrcW-1:0] wstart_reg, wend_reg;
    logic [BytW-1:0] ref_reg, alloc_reg;
    logic            more_reg;
    logic [IdxW-1:0] idx_reg, rd_idx, hit_idx_reg, free_idx_reg;
    logic            free_found_reg;
    logic            rd_valid_reg;
    logic [CrcW-1:0] rd_crc_reg;
    logic [BlkW-1:0] rd_blk_reg;
    logic [BytW-1:0] rd_byt_reg;
    logic [IdxW-1:0] rd_at_reg;
    logic            div_done;
    logic [BytW-1:0] div_q;
    logic [BytW:0]   sum_ref, sum_alloc, sum_byt;
    logic [CrcW-1:0] span;
    logic            evict_now;

    // registered read port; address is hit index during update
    assign rd_idx = cmd.hit_upd ? hit_idx_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        rd_crc_reg <= mem_crc[rd_idx];
        rd_blk_reg <= mem_blk[rd_idx];
        rd_byt_reg <= mem_byt[rd_idx];
        rd_at_reg  <= rd_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= mem_vld[rd_idx];
    end

    // single write port
    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            mem_crc[free_idx_reg] <= crc_reg;
            mem_blk[free_idx_reg] <= BlkW'(1);
            mem_byt[free_idx_reg] <= BytW'(len_reg);
        end
        else if (cmd.hit_upd && rd_at_reg == hit_idx_reg)
        begin
            mem_blk[hit_idx_reg] <= (rd_blk_reg == MAX32) ? rd_blk_reg : rd_blk_reg + 1'b1;
            mem_byt[hit_idx_reg] <= sum_byt[BytW] ? MAX48 : sum_byt[BytW-1:0];
        end
    end
    assign sum_byt = {1'b0, rd_byt_reg} + (BytW+1)'(len_reg);

    // eviction of the entry read last cycle
    assign evict_now = cmd.evict && rd_valid_reg && rd_crc_reg >= wend_reg;

    // valid bits, one write a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.fill)
            mem_vld[free_idx_reg] <= 1'b1;
        else if (cmd.wipe)
            mem_vld[idx_reg] <= 1'b0;
        else if (cmd.unset || evict_now)
            mem_vld[rd_at_reg] <= 1'b0;
    end

    assign span = wend_reg - wstart_reg - 1'b1;
    assign sum_ref   = {1'b0, ref_reg} + {1'b0, rd_byt_reg};
    assign sum_alloc = {1'b0, alloc_reg} + {1'b0, div_q};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0; wstart_reg <= '0; wend_reg <= '0;
            ref_reg <= '0; alloc_reg <= '0; more_reg <= 1'b0; idx_reg <= '0;
            hit_idx_reg <= '0; free_idx_reg <= '0; free_found_reg <= 1'b0;
            req_reg <= '0; crc_reg <= '0; len_reg <= '0;
            o_status <= '0; o_shrunk <= 1'b0; o_ref <= '0; o_alloc <= '0;
            o_more <= 1'b0; o_start <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                req_reg <= in_req; crc_reg <= in_crc; len_reg <= in_len;
                more_reg <= 1'b0;
            end
            if (cmd.clr_tot)
            begin
                wstart_reg <= '0; wend_reg <= '0; ref_reg <= '0; alloc_reg <= '0;
            end
            if (cmd.shrink)
                wend_reg <= wstart_reg + {1'b0, span[CrcW-1:1]};
            if (cmd.scan_rst)
            begin
                idx_reg <= '0; free_found_reg <= 1'b0;
            end
            else if (cmd.scan_inc)
                idx_reg <= idx_reg + 1'b1;
            if (evict_now && count_reg != '0)
                count_reg <= count_reg - 1'b1;
            if (cmd.look)
            begin
                if (rd_valid_reg && rd_crc_reg == crc_reg)
                    hit_idx_reg <= rd_at_reg;
                if (!rd_valid_reg && !free_found_reg)
                begin
                    free_found_reg <= 1'b1; free_idx_reg <= rd_at_reg;
                end
            end
            if (cmd.fill)
                count_reg <= count_reg + 1'b1;
            if (cmd.clr_step)
                count_reg <= '0;
            if (cmd.acc)
            begin
                ref_reg   <= sum_ref[BytW] ? MAX48 : sum_ref[BytW-1:0];
                alloc_reg <= sum_alloc[BytW] ? MAX48 : sum_alloc[BytW-1:0];
            end
            if (cmd.pass_end)
            begin
                more_reg <= wend_reg != '0;
                wstart_reg <= wend_reg; wend_reg <= '0;
            end
            if (cmd.out_load)
            begin
                o_status <= cmd.status; o_shrunk <= cmd.shrunk;
                o_ref <= ref_reg; o_alloc <= alloc_reg;
                o_more <= more_reg; o_start <= wstart_reg;
            end
        end
    end

    cdre_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(rd_byt_reg), .divisor(rd_blk_reg),
        .done(div_done), .quotient(div_q)
    );

    always_comb
    begin
        stat.req        = req_reg;
        stat.outside    = (wstart_reg != wend_reg) &&
            ((crc_reg < wstart_reg) || (wend_reg != '0 && crc_reg >= wend_reg));
        stat.over_limit = CmpW'(count_reg) > CmpW'(entry_limit);
        stat.scan_last  = rd_at_reg == IdxW'(TABLE_DEPTH - 1);
        stat.idx_last   = idx_reg == IdxW'(TABLE_DEPTH - 1);
        stat.match      = rd_valid_reg && rd_crc_reg == crc_reg;
        stat.any_free   = free_found_reg || !rd_valid_reg;
        stat.div_done   = div_done;
        stat.valid_ent  = rd_valid_reg && rd_blk_reg != '0;
    end
endmodule

// ===== design/cdre_ctrl.sv =====
`timescale 1ns / 1ps
module cdre_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  cdre_pkg::stat_t stat,
    output cdre_pkg::cmd_t  cmd
);
    import cdre_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   shr_reg, shr_next;
    logic   prim_reg, prim_next;  // read pipeline primed
    logic   hit_reg, hit_next;
    logic [2:0] st_reg, st_next;

    // clearing pass over the valid bits follows reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE; ov_reg <= 1'b0; shr_reg <= 1'b0;
            prim_reg <= 1'b0; hit_reg <= 1'b0; st_reg <= ST_CTRL;
        end
        else
        begin
            state_reg <= state_next; ov_reg <= ov_next; shr_reg <= shr_next;
            prim_reg <= prim_next; hit_reg <= hit_next; st_reg <= st_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg; ov_next = ov_reg; shr_next = shr_reg;
        prim_next = prim_reg; hit_next = hit_reg; st_next = st_reg;
        cmd = '0;
        in_ready = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !ov_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.latch = 1'b1; shr_next = 1'b0; hit_next = 1'b0;
                    state_next = S_CLEAR;
                end
            end
            // decode the transaction
            S_CLEAR:
            begin
                cmd.scan_rst = 1'b1; prim_next = 1'b0;
                unique case (stat.req)
                    REQ_RECORD:
                    begin
                        if (stat.outside)
                        begin
                            st_next = ST_OUTSIDE; state_next = S_OUT;
                        end
                        else if (stat.over_limit)
                        begin
                            cmd.shrink = 1'b1; shr_next = 1'b1; state_next = S_EVICT;
                        end
                        else
                            state_next = S_LOOK;
                    end
                    REQ_END:
                    begin
                        st_next = ST_CTRL; state_next = S_SUM;
                    end
                    REQ_START:
                    begin
                        cmd.clr_tot = 1'b1; cmd.clr_step = 1'b1;
                        st_next = ST_CTRL; state_next = S_WIPE;
                    end
                    default:
                    begin
                        st_next = ST_CTRL; state_next = S_OUT;
                    end
                endcase
            end
            // clear every valid bit; after reset req is a record, so go idle
            S_WIPE:
            begin
                cmd.wipe = 1'b1; cmd.scan_inc = 1'b1;
                if (stat.idx_last)
                    state_next = (stat.req == REQ_START) ? S_OUT : S_IDLE;
            end
            S_EVICT:
            begin
                cmd.scan_inc = 1'b1;
                if (prim_reg)
                begin
                    cmd.evict = 1'b1;
                    if (stat.scan_last)
                    begin
                        cmd.scan_rst = 1'b1; prim_next = 1'b0; state_next = S_LOOK;
                    end
                end
                else
                    prim_next = 1'b1;
            end
            S_LOOK:
            begin
                cmd.scan_inc = 1'b1;
                if (prim_reg)
                begin
                    cmd.look = 1'b1;
                    if (stat.match)
                    begin
                        hit_next = 1'b1; prim_next = 1'b0; state_next = S_FILL;
                    end
                    else if (stat.scan_last)
                    begin
                        prim_next = 1'b0;
                        if (stat.any_free)
                            state_next = S_FILL;
                        else
                        begin
                            st_next = ST_DROP; state_next = S_OUT;
                        end
                    end
                end
                else
                    prim_next = 1'b1;
            end
            // hit needs a read of the hit entry then write
            S_FILL:
            begin
                if (hit_reg)
                begin
                    cmd.hit_upd = 1'b1;
                    if (prim_reg)
                    begin
                        st_next = ST_HIT; state_next = S_OUT;
                    end
                    else
                        prim_next = 1'b1;
                end
                else
                begin
                    cmd.fill = 1'b1; st_next = ST_NEW; state_next = S_OUT;
                end
            end
            // entries are cleared one by one as the sum scan leaves them
            S_SUM:
            begin
                if (prim_reg)
                begin
                    if (stat.valid_ent)
                    begin
                        cmd.div_start = 1'b1; state_next = S_DIV;
                    end
                    else if (stat.scan_last)
                    begin
                        cmd.unset = 1'b1; cmd.clr_step = 1'b1; cmd.pass_end = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.unset = 1'b1; cmd.scan_inc = 1'b1; prim_next = 1'b0;
                    end
                end
                else
                    prim_next = 1'b1;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1; cmd.unset = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.clr_step = 1'b1; cmd.pass_end = 1'b1; state_next = S_OUT;
                end
                else
                begin
                    cmd.scan_inc = 1'b1; prim_next = 1'b0; state_next = S_SUM;
                end
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    cmd.out_load = 1'b1; cmd.status = st_reg; cmd.shrunk = shr_reg;
                    ov_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== design/crc_dedup_ratio_estimator.sv =====
// new record or hit: a sweep of the table looks up the crc, stopping at a match; when the
//   window is halved, an eviction sweep comes first, then the lookup sweep
// end of pass: sweep of every entry, 48-bit serial divider for each counted entry
// start of run: a sweep that clears the valid bits
// flow: one item at a time; the next is taken only once no result waits, or as it is taken
// reset: window, totals cleared at once, then a pass clears the valid bits
//   before the first transaction is taken; entry_limit returns to 768
`timescale 1ns / 1ps
module crc_dedup_ratio_estimator #(
    parameter int TABLE_DEPTH = 1024
) (
    input logic clk,
    input logic rst_n,
    cdre_req_if.sink   req,
    cdre_res_if.source res,
    cdre_cfg_if.sink   cfg
);
    import cdre_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [LimW-1:0] limit_reg;

    // configuration register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LimW'(768);
        else if (cfg.valid)
            limit_reg <= cfg.entry_limit;
    end

    cdre_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(res.valid), .out_ready(res.ready), .stat(stat), .cmd(cmd)
    );

    cdre_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_req(req.req_type), .in_crc(req.block_crc), .in_len(req.block_len),
        .entry_limit(limit_reg),
        .o_status(res.record_status), .o_shrunk(res.window_shrunk),
        .o_ref(res.referenced_total), .o_alloc(res.allocated_total),
        .o_more(res.more_passes), .o_start(res.next_window_start)
    );
endmodule
